>>> sv/ppm_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// PPM frame decoder assertion macros
// Clocked assertion helpers used by the decoder top level; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_MACROS_SVH
`define PPM_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// prop is checked on every rising clk edge outside reset
`define PFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pfd: assertion failed");
// expr must never be true outside reset
`define PFD_ASSERT_NEVER(lbl, expr) \
	`PFD_ASSERT(lbl, !(expr))
`else
`define PFD_ASSERT(lbl, prop)
`define PFD_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> sv/pfd_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Widths, register indexes, FSM state type and controller/datapath structs.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int EDGE_W     = 32;
	localparam int SYNC_W     = 16;
	localparam int CNT_W      = 4;
	localparam int IDX_W      = 3;
	localparam int WIDTH_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - WIDTH_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

	localparam logic [SYNC_W-1:0] SYNC_LENGTH_RST   = 16'd4000;
	localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 4'd8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} pfd_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // input transaction accepted this cycle
		logic load;   // load next channel result into output register
	} pfd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sync;      // gap of incoming edge reaches sync length
		logic cnt_zero;  // effective channel count is zero
		logic last;      // emit counter points at final channel
		logic out_free;  // output register can take a result
	} pfd_sts_t;

endpackage

>>> sv/pfd_ctrl.sv
// ----------------------------------------------------------------------------
// PPM frame decoder controller
// Two-state sequencer: take an edge, then stream the channel table on sync.
// ----------------------------------------------------------------------------
module pfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  pfd_pkg::pfd_sts_t sts,
	output pfd_pkg::pfd_cmd_t cmd
);
	import pfd_pkg::*;

	pfd_state_t state_q;
	pfd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.sync && !sts.cnt_zero) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/pfd_datapath.sv
// ----------------------------------------------------------------------------
// PPM frame decoder datapath
// Gap subtract/compare, channel width table, emit counter, output register.
// ----------------------------------------------------------------------------
module pfd_datapath #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [pfd_pkg::EDGE_W-1:0]        edge_time,
	input  pfd_pkg::pfd_cmd_t                 cmd,
	output pfd_pkg::pfd_sts_t                 sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pfd_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);
	import pfd_pkg::*;

	localparam int TW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [SYNC_W-1:0]  sync_len_q;
	logic [CNT_W-1:0]   chan_cnt_q;
	logic [EDGE_W-1:0]  last_edge_q;
	logic [CNT_W-1:0]   next_ch_q;
	logic [CNT_W-1:0]   emit_q;
	logic [WIDTH_W-1:0] widths_q [MAX_CHANNELS];

	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_valid_q;
	logic                  out_last_q;

	logic [EDGE_W-1:0] gap;
	logic [CNT_W-1:0]  count;
	logic              last_ch;

	assign gap = edge_time - last_edge_q;

	// clamp the programmed channel count to the table depth
	assign count = ({1'b0, chan_cnt_q} > (CNT_W+1)'(MAX_CHANNELS))
		? CNT_W'(MAX_CHANNELS) : chan_cnt_q;

	assign last_ch = (CNT_W'(emit_q + 1'b1) == count);

	assign sts.sync     = (gap >= {{(EDGE_W-SYNC_W){1'b0}}, sync_len_q});
	assign sts.cnt_zero = (count == '0);
	assign sts.last     = last_ch;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_len_q <= SYNC_LENGTH_RST;
			chan_cnt_q <= CHANNEL_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_LENGTH:   sync_len_q <= cfg_wdata[SYNC_W-1:0];
				REG_CHANNEL_COUNT: chan_cnt_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			next_ch_q   <= '0;
			emit_q      <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				widths_q[i] <= '0;
			end
		end else begin
			if (cmd.take) begin
				last_edge_q <= edge_time;
				if (sts.sync) begin
					next_ch_q <= '0;
					emit_q    <= '0;
				end else if (next_ch_q < count) begin
					widths_q[next_ch_q[TW-1:0]] <= gap[WIDTH_W-1:0];
					next_ch_q <= CNT_W'(next_ch_q + 1'b1);
				end
			end
			if (cmd.load) begin
				emit_q <= CNT_W'(emit_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, widths_q[emit_q[TW-1:0]], emit_q[IDX_W-1:0]};
			out_last_q <= last_ch;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> sv/ppm_frame_decoder.sv
// ----------------------------------------------------------------------------
// PPM frame decoder
// Turns falling-edge timestamps of a PPM stream into per-channel pulse widths.
// ----------------------------------------------------------------------------
// Each input transaction carries one falling-edge timestamp in microseconds
// (wrapping modulo 2^32). The gap to the previous edge is taken in the cycle
// the transaction is accepted. A gap shorter than sync_length is stored as
// the width of the next channel of the frame, up to channel_count channels
// (clamped to MAX_CHANNELS); further short gaps only move the timestamp on.
// A gap of at least sync_length is the frame sync: the channel index restarts,
// the first channel_count widths (clamped) go out, channel 0 first, one result
// per cycle while the sink keeps up, with tlast on the final channel. Widths
// persist across frames and are zero after reset; the very first gap is
// measured from timestamp 0. A non-sync edge does not hold the input; a sync
// edge with channels to send holds it while the table streams out, paced by
// the single output register and its emit counter and by sink stalls. The
// next edge may be accepted while the last result still waits in the output
// register. The user must write configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_macros.svh"

module ppm_frame_decoder #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration: 0 = sync_length, 1 = channel_count
	input  logic                           cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// edge timestamps
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pfd_pkg::EDGE_W-1:0]     s_tdata,   // [31:0] edge_time
	// channel results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfd_pkg::OUT_DATA_W-1:0] m_tdata,   // [2:0] channel_index,
	                                                  // [18:3] pulse_width,
	                                                  // [23:19] zero
	output logic                           m_tlast    // frame_last
);
	import pfd_pkg::*;

	pfd_cmd_t cmd;
	pfd_sts_t sts;

	// sequencer: idle / streaming the table
	pfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// gap arithmetic, width table and output register
	pfd_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.edge_time (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// an edge is never taken in the same cycle as a result is loaded
	`PFD_ASSERT_NEVER(a_take_load_excl, cmd.take && cmd.load)
	// a sync with channels to send blocks the input on the next cycle
	`PFD_ASSERT(a_sync_blocks_input, cmd.take && sts.sync && !sts.cnt_zero |=> !s_tready)
	// loading the final channel presents a valid result flagged last
	`PFD_ASSERT(a_last_loaded, cmd.load && sts.last |=> m_tvalid && m_tlast)
	// a result is only loaded when the output register has room
	`PFD_ASSERT(a_load_has_room, cmd.load |-> sts.out_free)

endmodule

>>> tb/sv/ppm_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// PPM frame decoder testbench
// Streams edge timestamps into the decoder and checks every channel result
// against a cycle-free model of the gap, channel table and frame sync logic.
// ----------------------------------------------------------------------------
// A directed run under the reset configuration covers the first gap from
// timestamp 0, the gap just below and exactly at sync, timestamp wrap, repeated
// timestamps, extra pulses and widths kept from earlier frames. Random phases
// then sweep both registers (sync length 0, 1 and 65535, channel count 0, 1,
// 8 and above 8) with mostly well-formed frames, some timestamp jumps and the
// occasional drain. Sender bursts and sink stalls are random throughout.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfd_pkg::*;

	localparam int NUM_CH = 8;
	localparam int MAX_REPORTS = 10;

	// one expected channel result
	typedef struct {
		logic [IDX_W-1:0]   idx;
		logic [WIDTH_W-1:0] width;
		logic               last;
	} chan_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the decoder state and holds the results still owed
	// ------------------------------------------------------------------------
	class ppm_scoreboard;
		logic [SYNC_W-1:0]  sync_len;
		logic [CNT_W-1:0]   chan_cnt;
		logic [EDGE_W-1:0]  prev_edge;
		logic [CNT_W-1:0]   next_chan;
		logic [WIDTH_W-1:0] widths [NUM_CH];
		chan_result_t       owed_q [$];
		int                 errors;

		function new();
			sync_len  = SYNC_LENGTH_RST;
			chan_cnt  = CHANNEL_COUNT_RST;
			prev_edge = '0;
			next_chan = '0;
			foreach (widths[k])
				widths[k] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_SYNC_LENGTH)
				sync_len = val[SYNC_W-1:0];
			else if (idx == REG_CHANNEL_COUNT)
				chan_cnt = val[CNT_W-1:0];
		endfunction

		// accepted edge transaction: work out gap, store or emit
		function void note_edge(logic [EDGE_W-1:0] t);
			logic [EDGE_W-1:0] gap;
			int                n_act;
			chan_result_t      r;
			gap       = t - prev_edge;	// wraps modulo 2^32
			prev_edge = t;
			n_act     = (chan_cnt > NUM_CH) ? NUM_CH : int'(chan_cnt);
			if (gap >= {{(EDGE_W-SYNC_W){1'b0}}, sync_len}) begin
				next_chan = '0;
				for (int k = 0; k < n_act; k++) begin
					r.idx   = k[IDX_W-1:0];
					r.width = widths[k];
					r.last  = (k == n_act - 1);
					owed_q.push_back(r);
				end
			end else if (int'(next_chan) < n_act) begin
				widths[next_chan] = gap[WIDTH_W-1:0];
				next_chan         = next_chan + 1'b1;
			end
		endfunction

		// accepted result transaction: compare with oldest owed result
		function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
			chan_result_t r;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR %0t: unexpected result idx=%0d width=%0d last=%0b",
						$realtime, data[IDX_W-1:0], data[IDX_W +: WIDTH_W], last);
				return;
			end
			r = owed_q.pop_front();
			if (data[IDX_W-1:0] !== r.idx || data[IDX_W +: WIDTH_W] !== r.width ||
			    data[OUT_DATA_W-1 -: OUT_PAD_W] !== '0 || last !== r.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR %0t: exp idx=%0d width=%0d last=%0b pad=0, got idx=%0d width=%0d last=%0b pad=%0h",
						$realtime, r.idx, r.width, r.last, data[IDX_W-1:0],
						data[IDX_W +: WIDTH_W], last, data[OUT_DATA_W-1 -: OUT_PAD_W]);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals, clock, DUT
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [EDGE_W-1:0]     s_tdata   = '0;	// [31:0] edge_time
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;		// [2:0] channel_index, [18:3] pulse_width, [23:19] zero
	logic                  m_tlast;		// frame_last

	ppm_scoreboard sb = new();

	// current register values, used to shape the stimulus
	int unsigned cur_sync = SYNC_LENGTH_RST;
	int unsigned cur_cnt  = CHANNEL_COUNT_RST;

	// sender burst state
	int burst_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ppm_frame_decoder #(
		.MAX_CHANNELS(NUM_CH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// ------------------------------------------------------------------------
	// Sink: checks accepted results, stalls on a pattern whose mode is redrawn
	// at random (always ready / mostly ready / mostly stalled)
	// ------------------------------------------------------------------------
	int sink_cyc  = 0;
	int sink_mode = 0;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			sink_cyc = sink_cyc + 1;
			if (sink_cyc % 48 == 0)
				sink_mode = $urandom_range(0, 2);
			case (sink_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Source tasks
	// ------------------------------------------------------------------------

	// one edge transaction; bursts of random length with random gaps between
	task automatic send_edge(input logic [EDGE_W-1:0] t);
		int idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (idle > 0) begin
				s_tvalid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_edge(t);
		burst_left--;
	endtask

	// hold the source off until every owed result is out, then let a
	// non-sync edge or the last result leave the pipeline
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, on consecutive cycles, only with the block idle
	task automatic configure(input int unsigned sync_val, input int unsigned cnt_val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SYNC_LENGTH;
		cfg_wdata <= sync_val[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(REG_SYNC_LENGTH, sync_val[CFG_DATA_W-1:0]);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_wdata <= cnt_val[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(REG_CHANNEL_COUNT, cnt_val[CFG_DATA_W-1:0]);
		cfg_we   <= 1'b0;
		cur_sync = sync_val;
		cur_cnt  = cnt_val;
	endtask

	// gap that marks frame sync under the current sync length
	function automatic logic [EDGE_W-1:0] sync_gap();
		case ($urandom_range(0, 7))
			0: return $urandom | 32'h0001_0000;	// above any sync length
			1: return cur_sync;			// exactly at the threshold
			default: return cur_sync + $urandom_range(0, 3000);
		endcase
	endfunction

	// gap for a channel pulse, below the sync length where one exists
	function automatic logic [EDGE_W-1:0] chan_gap();
		if (cur_sync == 0)
			return $urandom;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return cur_sync - 1;
			default: return $urandom_range(0, cur_sync - 1);
		endcase
	endfunction

	// frames of sync plus a random number of channel pulses, sometimes too
	// few or too many; one pulse in ten is a jump to a random timestamp
	task automatic run_frames(input int n_items);
		logic [EDGE_W-1:0] now;
		int                sent;
		int                pulses;
		int                n_act;
		now   = $urandom;
		sent  = 0;
		n_act = (cur_cnt > NUM_CH) ? NUM_CH : cur_cnt;
		while (sent < n_items) begin
			now = now + sync_gap();
			send_edge(now);
			sent++;
			pulses = $urandom_range(0, n_act + 2);
			for (int p = 0; p < pulses; p++) begin
				if ($urandom_range(0, 9) == 0)
					now = $urandom;
				else
					now = now + chan_gap();
				send_edge(now);
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	logic [EDGE_W-1:0] dir_edges [] = '{
		32'd100,		// first gap measured from 0
		32'd1600,		// 1500
		32'd5599,		// 3999, one below sync
		32'd9599,		// 4000, sync: channels 3 to 7 still zero
		32'hFFFF_FF00,		// huge gap, sync again
		32'h0000_0010,		// wraps, gap 0x110
		32'h0000_0010,		// same timestamp, gap 0
		32'h0000_0011,		// gap 1
		32'd4016,		// 3999
		32'd6016,
		32'd7016,
		32'd8016,
		32'd9016,		// channel 7 filled
		32'd9516,		// extra pulse, dropped
		32'd10216,		// extra pulse, dropped
		32'hFFFF_FFFF,		// sync with full table
		32'h0000_0000,		// wraps, gap 1
		32'h0000_FFFF		// sync, only channel 0 refreshed
	};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration
		foreach (dir_edges[i])
			send_edge(dir_edges[i]);

		// random phases over the register range
		configure(1500, 8);	run_frames(25);
		configure(65535, 15);	run_frames(25);	// count above the table size
		configure(1, 3);	run_frames(20);
		configure(0, 5);	run_frames(20);	// every edge is a sync
		configure(3000, 0);	run_frames(25);	// no channels at all
		configure(2000, 1);	run_frames(25);
		configure(4000, 8);	run_frames(30);
		configure(800, 9);	run_frames(30);

		drain();
		repeat (16) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("ERROR: %0d results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
